@@ rtl/mtcm_pkg.sv @@
// Package for the masked two-color cell mean block.
// Field widths, the cell record passed from the accumulator to the divider, queue status.
// No dependencies.
`default_nettype none
package mtcm_pkg;

	localparam int CHAN_W          = 8;   // one pixel channel
	localparam int NUM_CH          = 4;   // channels per pixel
	localparam int NUM_CLASS       = 2;   // background, foreground
	localparam int NUM_LANES       = NUM_CLASS * NUM_CH;
	localparam int SUM_W           = 14;  // class sums wrap modulo 2^14
	localparam int WEIGHT_W        = 7;
	localparam int S_TDATA_W       = 48;  // 4 x 8 channels + 2 x 7 weights, padded
	localparam int M_TDATA_W       = NUM_LANES * CHAN_W;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Lanes 0..3 hold background channels 0..3, lanes 4..7 foreground.
	typedef struct packed {
		logic [NUM_LANES-1:0][SUM_W-1:0] sums;
		logic [WEIGHT_W-1:0]             fore_w;
		logic [WEIGHT_W-1:0]             back_w;
	} cell_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

@@ rtl/mtcm_front.sv @@
// Front end: takes pixels, adds channels into the class sums, pushes finished cells.
// Depends on mtcm_pkg.
`default_nettype none
module mtcm_front
	import mtcm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic                 s_tuser,
	input  wire logic                 s_tlast,
	input  wire q_stat_t              q_stat,
	output logic                      push,
	output cell_t                     push_cell
);

	logic [NUM_LANES-1:0][SUM_W-1:0] sums_q;
	logic [NUM_LANES-1:0][SUM_W-1:0] sums_nxt;
	logic [NUM_CH-1:0][CHAN_W-1:0]   chan;
	logic                            accept;

	assign chan     = s_tdata[NUM_CH*CHAN_W-1:0];
	assign s_tready = ~q_stat.full;
	assign accept   = s_tvalid & s_tready;
	assign push     = accept & s_tlast;

	always_comb begin
		for (int cl = 0; cl < NUM_CLASS; cl++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (s_tuser == cl[0]) begin
					sums_nxt[cl*NUM_CH+c] = sums_q[cl*NUM_CH+c]
						+ {{(SUM_W-CHAN_W){1'b0}}, chan[c]};
				end else begin
					sums_nxt[cl*NUM_CH+c] = sums_q[cl*NUM_CH+c];
				end
			end
		end
	end

	assign push_cell.sums   = sums_nxt;
	assign push_cell.fore_w = s_tdata[NUM_CH*CHAN_W +: WEIGHT_W];
	assign push_cell.back_w = s_tdata[NUM_CH*CHAN_W+WEIGHT_W +: WEIGHT_W];

	// sums restart from zero after the last pixel of a cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				sums_q <= '0;
			end else begin
				sums_q <= sums_nxt;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/mtcm_queue.sv @@
// Short queue of finished cells between the accumulator and the divider.
// Depends on mtcm_pkg.
`default_nettype none
module mtcm_queue
	import mtcm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cell_t push_cell,
	input  wire logic  pop,
	output cell_t      pop_cell,
	output q_stat_t    q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push & ~q_stat.full;
	assign do_pop       = pop & ~q_stat.empty;
	assign pop_cell     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/mtcm_back.sv @@
// Back end: eight restoring dividers, one quotient bit per cycle, and the output register.
// Depends on mtcm_pkg.
`default_nettype none
module mtcm_back
	import mtcm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire q_stat_t      q_stat,
	output logic              pop,
	input  wire cell_t        pop_cell,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	localparam int CNT_W = $clog2(SUM_W);

	logic [1:0]                         state_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [NUM_LANES-1:0][SUM_W-1:0]    quo_q;
	logic [NUM_LANES-1:0][WEIGHT_W-1:0] rem_q;
	logic [NUM_LANES-1:0][WEIGHT_W-1:0] div_q;
	logic [NUM_LANES-1:0][SUM_W-1:0]    quo_nxt;
	logic [NUM_LANES-1:0][WEIGHT_W-1:0] rem_nxt;
	logic [NUM_LANES-1:0][WEIGHT_W:0]   sh;
	logic [NUM_LANES-1:0][WEIGHT_W:0]   diff;
	logic [NUM_LANES-1:0]               ge;
	logic [M_TDATA_W-1:0]               m_tdata_q;
	logic                               m_tvalid_q;
	logic                               out_free;
	logic                               out_load;

	assign pop      = (state_q == ST_IDLE) & ~q_stat.empty;
	assign out_free = ~m_tvalid_q | m_tready;
	assign out_load = (state_q == ST_HOLD) & out_free;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// one restoring step per lane
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			sh[l]      = {rem_q[l], quo_q[l][SUM_W-1]};
			diff[l]    = sh[l] - {1'b0, div_q[l]};
			ge[l]      = (sh[l] >= {1'b0, div_q[l]});
			rem_nxt[l] = ge[l] ? diff[l][WEIGHT_W-1:0] : sh[l][WEIGHT_W-1:0];
			quo_nxt[l] = {quo_q[l][SUM_W-2:0], ge[l]};
		end
	end

	// weight zero divides by one so the sum passes through
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				quo_q[l] <= pop_cell.sums[l];
				rem_q[l] <= '0;
				if (l < NUM_CH) begin
					div_q[l] <= (pop_cell.back_w == '0) ? WEIGHT_W'(1) : pop_cell.back_w;
				end else begin
					div_q[l] <= (pop_cell.fore_w == '0) ? WEIGHT_W'(1) : pop_cell.fore_w;
				end
			end
		end else if (state_q == ST_RUN) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
		if (out_load) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				m_tdata_q[l*CHAN_W +: CHAN_W] <= quo_q[l][CHAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_HOLD;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/masked_two_color_cell_mean.sv @@
// Top level of the masked two-color cell mean block.
// Accumulator front end, cell queue and divider back end; depends on mtcm_pkg,
// mtcm_front, mtcm_queue and mtcm_back.
//
// Usage:
//   Slave channel: one pixel per request. s_tdata carries the four channels and the
//   two class weights, s_tuser the pen bit (0 background, 1 foreground), s_tlast the
//   last pixel of a cell. Weights are read only with the last pixel.
//   Master channel: one request per cell, the background and foreground mean colors.
//   Throughput: one pixel per cycle while s_tready is high. The divider back end takes
//   one cell at a time (a load, one step per quotient bit, a hand-off), so short cells
//   fill the cell queue and then s_tready drops until the divider catches up.
//   Path: after the last pixel is accepted, the cell goes through the queue, the load,
//   the quotient steps and the hand-off into the output register.
//   Stall: a result held by a low m_tready keeps m_tdata steady; the next cell waits
//   in the divider, then the queue, and only then is s_tready deasserted.
//   Reset: arst_n clears the sums, empties the queue and drops m_tvalid; no clearing
//   pass, the block takes pixels in the first cycle after reset.
`default_nettype none
module masked_two_color_cell_mean
	import mtcm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // cells buffered, 2 or more
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [7:0] chan_zero, [15:8] chan_one, [23:16] chan_two, [31:24] chan_three,
	// [38:32] fore_weight, [45:39] back_weight, [47:46] zero
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// [0] pen
	input  wire logic                 s_tuser,
	input  wire logic                 s_tlast,          // last_pixel
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [7:0] back_zero, [15:8] back_one, [23:16] back_two, [31:24] back_three,
	// [39:32] fore_zero, [47:40] fore_one, [55:48] fore_two, [63:56] fore_three
	output logic [M_TDATA_W-1:0]      m_tdata
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	cell_t   push_cell;
	cell_t   pop_cell;

	// pixel accumulation, sums of the cell in progress
	mtcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_stat    (q_stat),
		.push      (push),
		.push_cell (push_cell)
	);

	// finished cells waiting for the divider
	mtcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cell (push_cell),
		.pop       (pop),
		.pop_cell  (pop_cell),
		.q_stat    (q_stat)
	);

	// per-channel division and result register
	mtcm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop      (pop),
		.pop_cell (pop_cell),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

@@ rtl/mtcm_checker.sv @@
// Port-level checker for the masked two-color cell mean block, with its bind.
// Depends on mtcm_pkg and masked_two_color_cell_mean.
`default_nettype none
module mtcm_checker
	import mtcm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 s_tlast,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	localparam int PEND_W = $clog2(QUEUE_DEPTH + 4);

	logic [PEND_W-1:0] pend_q;
	logic              cell_in;
	logic              cell_out;

	assign cell_in  = s_tvalid & s_tready & s_tlast;
	assign cell_out = m_tvalid & m_tready;

	// cells accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cell_in && !cell_out) begin
			pend_q <= pend_q + 1'b1;
		end else if (cell_out && !cell_in) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != '0)
		else $error("result without a finished cell");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == '0 |-> s_tready)
		else $error("input stalled with nothing in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(QUEUE_DEPTH + 2))
		else $error("more cells in flight than storage");

endmodule

bind masked_two_color_cell_mean mtcm_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_mtcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for masked_two_color_cell_mean: directed cells, then random cells.
// A local predictor of the class sums and means checks every request leaving the block.
// Depends on mtcm_pkg and masked_two_color_cell_mean.
`timescale 1ns / 100ps
module tb;
	import mtcm_pkg::*;

	localparam int LIMIT_CYCLES = 500000;  // far above the slowest legal run
	localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
	localparam int PHASE_PIX    = 175;     // pixels per random phase
	localparam int TAIL_CYCLES  = 40;      // idle margin after the final drain

	// One pixel request as the slave side sees it.
	typedef struct packed {
		logic [WEIGHT_W-1:0]          back_w;
		logic [WEIGHT_W-1:0]          fore_w;
		logic                         last;
		logic                         pen;
		logic [NUM_CH-1:0][CHAN_W-1:0] chan;
	} pixel_t;

	// One result request: background colors in the low half, as on m_tdata.
	typedef struct packed {
		logic [NUM_CH-1:0][CHAN_W-1:0] fore;
		logic [NUM_CH-1:0][CHAN_W-1:0] back;
	} cell_colors_t;

	typedef struct {
		pixel_t                 px;
		bit                     known;  // want is typed in, not predicted
		logic [M_TDATA_W-1:0]   want;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;   // chan_zero..chan_three, fore_weight, back_weight, pad
	logic                   s_tuser;   // pen
	logic                   s_tlast;   // last_pixel
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;   // back_zero..back_three, fore_zero..fore_three

	masked_two_color_cell_mean dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: lanes 0..3 background sums, 4..7 foreground sums.
	logic [SUM_W-1:0] run_sums [NUM_LANES];
	cell_colors_t     colors_due [$];     // expected colors, oldest first
	dir_row_t         dir_rows [$];

	int  errors          = 0;
	int  pixels_accepted = 0;
	int  cells_closed    = 0;
	int  colors_checked  = 0;
	int  cycles          = 0;
	bit  calm            = 1'b0;  // no gaps on either side while set
	bit  hold_req        = 1'b0;  // ask the receiver for a long hold-off

	string field_names [8] = '{"back_zero", "back_one", "back_two", "back_three",
		"fore_zero", "fore_one", "fore_two", "fore_three"};

	// Gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Add one pixel to its class; on the last pixel produce the two means and clear.
	function automatic bit fold_pixel(input pixel_t px, output cell_colors_t colors);
		int               base;
		logic [SUM_W-1:0] q;
		colors = '0;
		base = px.pen ? NUM_CH : 0;
		for (int c = 0; c < NUM_CH; c++)
			run_sums[base + c] = run_sums[base + c] + SUM_W'(px.chan[c]);  // wraps at 2^14
		if (!px.last)
			return 1'b0;
		for (int c = 0; c < NUM_CH; c++) begin
			// weight 0 or 1 passes the sum through undivided
			q = (px.back_w > 1) ? run_sums[c] / px.back_w : run_sums[c];
			colors.back[c] = q[CHAN_W-1:0];
			q = (px.fore_w > 1) ? run_sums[NUM_CH + c] / px.fore_w : run_sums[NUM_CH + c];
			colors.fore[c] = q[CHAN_W-1:0];
		end
		for (int i = 0; i < NUM_LANES; i++)
			run_sums[i] = '0;
		return 1'b1;
	endfunction

	// Offer one pixel after a random gap; valid stays high when there is no gap.
	task automatic send_pixel(input pixel_t px, input bit known, input logic [M_TDATA_W-1:0] want);
		int           gap;
		cell_colors_t colors;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, px.back_w, px.fore_w, px.chan};
		s_tuser  <= px.pen;
		s_tlast  <= px.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pixels_accepted++;
		if (fold_pixel(px, colors)) begin
			cells_closed++;
			colors_due.push_back(known ? cell_colors_t'(want) : colors);
		end
	endtask

	// One random cell. Weights are the true class counts unless odd_weights.
	// hot biases channels high so over-length cells wrap the sums.
	task automatic send_cell(input int len, input bit odd_weights, input bit hot);
		pixel_t px;
		int     n_fore;
		int     n_back;
		int     pen_pct;
		int     r;
		n_fore  = 0;
		n_back  = 0;
		pen_pct = $urandom_range(0, 4) * 25;  // some cells are one class only
		for (int i = 0; i < len; i++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				r = $urandom_range(0, 7);
				if (hot)
					px.chan[c] = CHAN_W'($urandom_range(200, 255));
				else if (r == 0)
					px.chan[c] = '0;
				else if (r == 1)
					px.chan[c] = '1;
				else
					px.chan[c] = CHAN_W'($urandom_range(0, 255));
			end
			px.pen = ($urandom_range(0, 99) < pen_pct);
			if (px.pen)
				n_fore++;
			else
				n_back++;
			px.last = (i == len - 1);
			// weights on non-last pixels must be ignored, so fill them with noise
			if (px.last && !odd_weights) begin
				px.fore_w = WEIGHT_W'(n_fore);
				px.back_w = WEIGHT_W'(n_back);
			end else begin
				px.fore_w = WEIGHT_W'($urandom_range(0, 127));
				px.back_w = WEIGHT_W'($urandom_range(0, 127));
			end
			send_pixel(px, 1'b0, '0);
		end
	endtask

	// Sender pause: drop valid and wait for every outstanding result.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (colors_due.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int g;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				g = gap_len();
				if (g > 0) begin
					m_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Result check, field by field against the oldest expectation.
	always @(posedge clk) begin : color_check
		logic [M_TDATA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (colors_due.size() == 0) begin
				errors++;
				if (errors <= 30)
					$display("%0t: unexpected result request, got %h", $time, m_tdata);
			end else begin
				want = colors_due.pop_front();
				colors_checked++;
				for (int f = 0; f < 2 * NUM_CH; f++)
					if (m_tdata[f*CHAN_W +: CHAN_W] !== want[f*CHAN_W +: CHAN_W]) begin
						errors++;
						if (errors <= 30)
							$display("%0t: %s expected %02h actual %02h", $time,
								field_names[f], want[f*CHAN_W +: CHAN_W],
								m_tdata[f*CHAN_W +: CHAN_W]);
					end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d results outstanding", $time, colors_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int phase_start;
		int r;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		for (int i = 0; i < NUM_LANES; i++)
			run_sums[i] = '0;

		// Directed cells. Typed rows are the easy ones: single class, weights 0, 1, 2 and 127, full scale.
		// one background pixel, weights zero: sums pass through, foreground empty
		dir_rows.push_back('{px: '{chan: 32'hffffffff, pen: 1'b0, last: 1'b1,
			fore_w: 7'd0, back_w: 7'd0}, known: 1'b1, want: 64'h00000000_ffffffff});
		// one foreground pixel, weights one
		dir_rows.push_back('{px: '{chan: 32'h04030201, pen: 1'b1, last: 1'b1,
			fore_w: 7'd1, back_w: 7'd1}, known: 1'b1, want: 64'h04030201_00000000});
		// weight one with a sum past 8 bits: only the low byte survives
		dir_rows.push_back('{px: '{chan: 32'h007f8180, pen: 1'b0, last: 1'b0,
			fore_w: 7'd0, back_w: 7'd5}, known: 1'b0, want: '0});
		dir_rows.push_back('{px: '{chan: 32'h007f8180, pen: 1'b0, last: 1'b1,
			fore_w: 7'd127, back_w: 7'd1}, known: 1'b1, want: 64'h00000000_00fe0200});
		// largest weight: 510 / 127 = 4
		dir_rows.push_back('{px: '{chan: 32'hffffffff, pen: 1'b1, last: 1'b0,
			fore_w: 7'd3, back_w: 7'd9}, known: 1'b0, want: '0});
		dir_rows.push_back('{px: '{chan: 32'hffffffff, pen: 1'b1, last: 1'b1,
			fore_w: 7'd127, back_w: 7'd127}, known: 1'b1, want: 64'h04040404_00000000});
		// full scale mean of two
		dir_rows.push_back('{px: '{chan: 32'hffffffff, pen: 1'b0, last: 1'b0,
			fore_w: 7'd0, back_w: 7'd0}, known: 1'b0, want: '0});
		dir_rows.push_back('{px: '{chan: 32'hffffffff, pen: 1'b0, last: 1'b1,
			fore_w: 7'd64, back_w: 7'd2}, known: 1'b1, want: 64'h00000000_ffffffff});
		// sums must have been cleared: an all-zero cell gives all zero
		dir_rows.push_back('{px: '{chan: 32'h00000000, pen: 1'b1, last: 1'b1,
			fore_w: 7'd0, back_w: 7'd0}, known: 1'b1, want: 64'h0});
		// mixed cell, both classes
		dir_rows.push_back('{px: '{chan: 32'h11223344, pen: 1'b0, last: 1'b0,
			fore_w: 7'd64, back_w: 7'd64}, known: 1'b0, want: '0});
		dir_rows.push_back('{px: '{chan: 32'ha5a5a5a5, pen: 1'b1, last: 1'b0,
			fore_w: 7'd0, back_w: 7'd0}, known: 1'b0, want: '0});
		dir_rows.push_back('{px: '{chan: 32'h5a5a5a5a, pen: 1'b1, last: 1'b0,
			fore_w: 7'd1, back_w: 7'd1}, known: 1'b0, want: '0});
		dir_rows.push_back('{px: '{chan: 32'h80808080, pen: 1'b0, last: 1'b1,
			fore_w: 7'd2, back_w: 7'd2}, known: 1'b0, want: '0});
		// nominal top weight, odd values
		dir_rows.push_back('{px: '{chan: 32'hdeadbeef, pen: 1'b0, last: 1'b1,
			fore_w: 7'd64, back_w: 7'd64}, known: 1'b0, want: '0});
		dir_rows.push_back('{px: '{chan: 32'h7f7f7f7f, pen: 1'b1, last: 1'b1,
			fore_w: 7'd3, back_w: 7'd0}, known: 1'b0, want: '0});
		// weights above the nominal range are plain divisors
		dir_rows.push_back('{px: '{chan: 32'hffffffff, pen: 1'b0, last: 1'b1,
			fore_w: 7'd100, back_w: 7'd65}, known: 1'b0, want: '0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_pixel(dir_rows[i].px, dir_rows[i].known, dir_rows[i].want);
		drain();

		// Random phases:
		//   0  mixed cell lengths, random gaps
		//   1  long receiver hold-off, no gaps, so the cell queue fills and s_tready drops
		//   2  mixed again after a full pause
		//   3  very short cells, keeps the divider behind the accumulator
		for (int ph = 0; ph < 4; ph++) begin
			phase_start = pixels_accepted;
			if (ph == 1) begin
				calm     = 1'b1;
				hold_req = 1'b1;
			end
			while (pixels_accepted - phase_start < PHASE_PIX) begin
				r = $urandom_range(0, 99);
				if (ph == 3 || (ph == 1 && r < 50))
					send_cell($urandom_range(1, 4), r < 10, 1'b0);
				else if (r < 5)
					send_cell($urandom_range(65, 90), 1'b0, 1'b1);  // sums wrap
				else if (r < 25)
					send_cell($urandom_range(16, 64), r < 10, 1'b0);
				else
					send_cell($urandom_range(1, 15), r > 90, 1'b0);
			end
			calm = 1'b0;
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d pixels in %0d cells, %0d color results compared;", pixels_accepted,
			cells_closed, colors_checked);
		$display("weights 0..127, over-length cells, a long output hold-off and idle pauses.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
